### sv/cpp_pkg.sv
// shared types and character constants for the controller packet parser
package cpp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TAG     = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    localparam logic [7:0] CH_START  = 8'h21;  // '!'
    localparam logic [7:0] CH_BUTTON = 8'h42;  // 'B'
    localparam logic [7:0] CH_QUAT   = 8'h51;  // 'Q'
    localparam logic [7:0] CH_ONE    = 8'h31;  // '1'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'

    localparam int LEN_BUTTON = 3;
    localparam int QUAT_WORDS = 4;
    localparam int LEN_QUAT   = QUAT_WORDS * 4;
    localparam int CNT_W      = $clog2(LEN_QUAT);

    localparam logic MSG_BUTTON = 1'b0;
    localparam logic MSG_QUAT   = 1'b1;

    localparam int OUT_DATA_W = 144;

endpackage

### sv/controller_packet_parser.sv
// controller packet parser: byte stream in, button and quaternion messages out
//
//  channel  | dir | tdata                                   | tuser
//  ---------+-----+-----------------------------------------+--------------
//  s (in)   | in  | rx_byte [7:0]                           | -
//  m (out)  | out | button_accepted, button_map, quat w/x/y/z | message_kind
//
// one received byte is taken every cycle; the byte that completes a message
// loads the output register in the same cycle it is taken, so a result shows in
// the cycle after its last byte. the only stall comes from the output register:
// the input is held off only while a result waits and the sink is not ready.
// synchronous active-low reset returns to idle and clears the map and words.
module controller_packet_parser #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // stream in
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] rx_byte
    // stream out
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [cpp_pkg::OUT_DATA_W-1:0] o_m_tdata,
        // [0] button_accepted, [8:1] button_map, [40:9] quat_w,
        // [72:41] quat_x, [104:73] quat_y, [136:105] quat_z, rest zero
    output logic         o_m_tuser    // [0] message_kind
);
    import cpp_pkg::*;

    // parser state
    t_phase             r_phase, n_phase;
    logic               r_is_quat, n_is_quat;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [7:0]         r_store [LEN_QUAT];
    logic [7:0]         r_buttons, n_buttons;
    logic [31:0]        r_quat [QUAT_WORDS];
    logic [31:0]        n_quat [QUAT_WORDS];

    // output register
    logic                  r_out_valid;
    logic                  r_out_kind, n_out_kind;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic                  n_emit;
    logic                  n_accepted;

    logic       in_req;
    logic [7:0] rx_byte;
    logic [7:0] btn_id;
    logic [7:0] btn_sel;

    // take a byte whenever the output slot is free or being drained
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_req     = i_s_tvalid && o_s_tready;
    assign rx_byte    = i_s_tdata;

    // button id from the first stored payload byte, wrapping below '1'
    assign btn_id  = r_store[0] - CH_ONE;
    assign btn_sel = 8'(1) << btn_id[2:0];

    always_comb begin
        n_phase    = r_phase;
        n_is_quat  = r_is_quat;
        n_count    = r_count;
        n_buttons  = r_buttons;
        n_quat     = r_quat;
        n_emit     = 1'b0;
        n_accepted = 1'b0;
        n_out_kind = MSG_BUTTON;
        if (in_req) begin
            unique case (r_phase)
                PH_TAG: begin
                    n_count = '0;
                    if (rx_byte == CH_BUTTON) begin
                        n_is_quat = 1'b0;
                        n_phase   = PH_PAYLOAD;
                    end else if (rx_byte == CH_QUAT) begin
                        n_is_quat = 1'b1;
                        n_phase   = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_PAYLOAD: begin
                    n_count = r_count + CNT_W'(1);
                    if (r_is_quat && r_count == CNT_W'(LEN_QUAT - 1)) begin
                        // last byte goes straight into the top of word three
                        n_phase    = PH_IDLE;
                        n_count    = '0;
                        n_emit     = 1'b1;
                        n_out_kind = MSG_QUAT;
                        for (int w = 0; w < QUAT_WORDS - 1; w++) begin
                            n_quat[w] = {r_store[4*w+3], r_store[4*w+2],
                                         r_store[4*w+1], r_store[4*w]};
                        end
                        n_quat[QUAT_WORDS-1] = {rx_byte,
                                                r_store[LEN_QUAT-2],
                                                r_store[LEN_QUAT-3],
                                                r_store[LEN_QUAT-4]};
                    end else if (!r_is_quat && r_count == CNT_W'(LEN_BUTTON - 1)) begin
                        // third button byte is ignored
                        n_phase    = PH_IDLE;
                        n_count    = '0;
                        n_emit     = 1'b1;
                        n_out_kind = MSG_BUTTON;
                        if (btn_id < 8'(NUM_BUTTONS)) begin
                            n_accepted = 1'b1;
                            if (r_store[1] != CH_ZERO) begin
                                n_buttons = r_buttons | btn_sel;
                            end else begin
                                n_buttons = r_buttons & ~btn_sel;
                            end
                        end
                    end
                end
                default: begin
                    // idle and the unused code wait for a start byte
                    n_phase = (rx_byte == CH_START) ? PH_TAG : PH_IDLE;
                end
            endcase
        end
        n_out_data = {7'd0, n_quat[3], n_quat[2], n_quat[1], n_quat[0],
                      n_buttons, n_accepted};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_is_quat   <= 1'b0;
            r_count     <= '0;
            r_buttons   <= '0;
            r_out_valid <= 1'b0;
            for (int w = 0; w < QUAT_WORDS; w++) begin
                r_quat[w] <= '0;
            end
        end else begin
            r_phase   <= n_phase;
            r_is_quat <= n_is_quat;
            r_count   <= n_count;
            r_buttons <= n_buttons;
            r_quat    <= n_quat;
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload bytes and result payload carry no reset
    always_ff @(posedge i_clk) begin
        if (in_req && r_phase == PH_PAYLOAD) begin
            r_store[r_count] <= rx_byte;
        end
        if (n_emit) begin
            r_out_kind <= n_out_kind;
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;

    // a new result only ever follows an accepted byte
    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_req))
        else $error("result appeared without an input request");

    // every completed message leaves the parser idle
    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_emit |=> r_phase == PH_IDLE)
        else $error("parser not idle after a completed message");

    // quaternion results never report a button update
    a_quat_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == MSG_QUAT) |-> !o_m_tdata[0])
        else $error("quaternion result flagged as button update");

    // a button payload count at its length would mean a missed completion
    a_button_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD && !r_is_quat) |-> r_count < CNT_W'(LEN_BUTTON))
        else $error("button payload overran its length");

endmodule

### bench/tb.sv
// testbench for the controller packet parser: byte stream in, predicted messages checked out
module tb;
    import cpp_pkg::*;

    localparam int NUM_BUTTONS  = 8;
    localparam int BYTE_TARGET  = 1600;     // input bytes to offer in total
    localparam int HOLD_CYCLES  = 400;      // long sink hold-off
    localparam int CYCLE_LIMIT  = 400000;   // generous timeout
    localparam int TAIL_CYCLES  = 10;       // settle time once everything has come back
    localparam int PRINT_LIMIT  = 40;

    // one completed message as the block reports it
    typedef struct packed {
        logic              kind;
        logic              accepted;
        logic [7:0]        map;
        logic [3:0][31:0]  quat;            // [0] w .. [3] z
    } t_message;

    // keeps its own copy of the parser state and predicts every message
    class message_predictor;
        t_phase            phase;
        bit                is_quat;
        int unsigned       count;
        logic [7:0]        payload [16];
        logic [7:0]        buttons;
        logic [3:0][31:0]  quat;
        t_message          expected_messages [$];
        int                errors;

        function new();
            phase   = PH_IDLE;
            is_quat = 1'b0;
            count   = 0;
            buttons = '0;
            quat    = '0;
            errors  = 0;
            foreach (payload[i]) payload[i] = '0;
        endfunction

        function int pending();
            return expected_messages.size();
        endfunction

        // advance the parser by one accepted byte, queue a message when one completes
        function void take_byte(logic [7:0] b);
            t_message    msg;
            logic [7:0]  id;
            int unsigned len;
            case (phase)
                PH_TAG: begin
                    count = 0;
                    if (b == CH_BUTTON) begin
                        is_quat = 1'b0;
                        phase   = PH_PAYLOAD;
                    end else if (b == CH_QUAT) begin
                        is_quat = 1'b1;
                        phase   = PH_PAYLOAD;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_PAYLOAD: begin
                    len = is_quat ? LEN_QUAT : LEN_BUTTON;
                    payload[count] = b;
                    count++;
                    if (count >= len) begin
                        phase        = PH_IDLE;
                        count        = 0;
                        msg.accepted = 1'b0;
                        if (is_quat) begin
                            for (int i = 0; i < QUAT_WORDS; i++)
                                quat[i] = {payload[4*i+3], payload[4*i+2],
                                           payload[4*i+1], payload[4*i]};
                            msg.kind = MSG_QUAT;
                        end else begin
                            // id wraps below '1', so one unsigned compare covers both ends
                            id = payload[0] - CH_ONE;
                            if (id < NUM_BUTTONS) begin
                                buttons[id[2:0]] = (payload[1] != CH_ZERO);
                                msg.accepted     = 1'b1;
                            end
                            msg.kind = MSG_BUTTON;
                        end
                        msg.map  = buttons;
                        msg.quat = quat;
                        expected_messages.push_back(msg);
                    end
                end
                default: begin
                    phase = (b == CH_START) ? PH_TAG : PH_IDLE;
                end
            endcase
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            if (errors < PRINT_LIMIT)
                $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        // compare one accepted message with the oldest prediction
        task check_message(logic kind, logic [OUT_DATA_W-1:0] data);
            t_message want;
            if (expected_messages.size() == 0) begin
                report_mismatch("message with none predicted", {31'd0, kind}, 32'd0);
            end else begin
                want = expected_messages.pop_front();
                if (kind !== want.kind)
                    report_mismatch("message_kind", {31'd0, kind}, {31'd0, want.kind});
                if (data[0] !== want.accepted)
                    report_mismatch("button_accepted", {31'd0, data[0]},
                                    {31'd0, want.accepted});
                if (data[8:1] !== want.map)
                    report_mismatch("button_map", {24'd0, data[8:1]}, {24'd0, want.map});
                if (data[40:9] !== want.quat[0])
                    report_mismatch("quat_w", data[40:9], want.quat[0]);
                if (data[72:41] !== want.quat[1])
                    report_mismatch("quat_x", data[72:41], want.quat[1]);
                if (data[104:73] !== want.quat[2])
                    report_mismatch("quat_y", data[104:73], want.quat[2]);
                if (data[136:105] !== want.quat[3])
                    report_mismatch("quat_z", data[136:105], want.quat[3]);
                if (data[OUT_DATA_W-1:137] !== '0)
                    report_mismatch("tdata padding", {25'd0, data[OUT_DATA_W-1:137]}, 32'd0);
            end
        endtask
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata  = '0;     // [7:0] rx_byte
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;           // [0] accepted, [8:1] map, then w, x, y, z
    logic                  o_m_tuser;           // [0] message_kind

    message_predictor predictor;

    int          cycle_count = 0;
    int          hold_token  = 0;       // bumped by the sender to ask for a long sink hold
    int          hold_seen   = 0;
    int          hold_left   = 0;
    logic [31:0] ready_pat   = '1;
    int          pat_left    = 0;
    int          burst_left  = 0;
    int          sent_bytes  = 0;

    logic [7:0] quat_bytes [16] = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'hfe, 8'h55, 8'haa,
                                    8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff};

    controller_packet_parser #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // sink ready: a long hold-off when the sender asks, else a reshuffled 32-bit pattern
    always @(posedge i_clk) begin
        if (hold_seen != hold_token) begin
            hold_seen  <= hold_token;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (pat_left == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pat <= '1;                     // no stalls at all
                1: ready_pat <= $urandom();
                2: ready_pat <= $urandom() | $urandom(); // light stalls
                default: ready_pat <= $urandom() & $urandom(); // heavy stalls
            endcase
            pat_left   <= 31;
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ready_pat[pat_left[4:0]];
            pat_left   <= pat_left - 1;
        end
    end

    // output monitor: values sampled as they stood at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            predictor.check_message(o_m_tuser, o_m_tdata);
    end

    // offer one byte, idling between bursts, and return once it is accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(64, 200)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        predictor.take_byte(b);
        burst_left--;
        sent_bytes++;
    endtask

    // stop offering and wait for every predicted message to come back
    task automatic pause_until_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (predictor.pending() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic send_button(input logic [7:0] id, input logic [7:0] value,
                               input logic [7:0] spare);
        send_byte(CH_START);
        send_byte(CH_BUTTON);
        send_byte(id);
        send_byte(value);
        send_byte(spare);
    endtask

    // one random packet, stray bytes or a broken header
    task automatic send_random_packet();
        logic [7:0] id;
        logic [7:0] value;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // ids mostly around the valid range so both edges get hit
            id    = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(8'h30, 8'h39))
                                               : 8'($urandom());
            value = ($urandom_range(0, 9) < 4) ? CH_ZERO : 8'($urandom());
            send_button(id, value, 8'($urandom()));
        end else if (pick < 80) begin
            send_byte(CH_START);
            send_byte(CH_QUAT);
            for (int i = 0; i < LEN_QUAT; i++) begin
                case ($urandom_range(0, 7))
                    0: send_byte(8'h00);
                    1: send_byte(8'hff);
                    default: send_byte(8'($urandom()));
                endcase
            end
        end else if (pick < 90) begin
            // broken header: start followed by a tag that is not known
            send_byte(CH_START);
            value = 8'($urandom());
            if (value == CH_BUTTON || value == CH_QUAT) value = CH_START;
            send_byte(value);
        end else begin
            // line noise while idle
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom()));
        end
    endtask

    initial begin
        bit held;
        bit drained;
        held      = 1'b0;
        drained   = 1'b0;
        predictor = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // set button one, third byte ignored
        send_button(CH_ONE, 8'hff, 8'h00);
        // id just above the range, map untouched
        send_button(8'(CH_ONE + NUM_BUTTONS), CH_ONE, 8'hff);
        // start used as a tag: back to idle, the tag that follows is plain noise
        send_byte(CH_START);
        send_byte(CH_START);
        send_byte(CH_BUTTON);
        // quaternion with all-zero and all-one bytes and single-bit patterns
        send_byte(CH_START);
        send_byte(CH_QUAT);
        foreach (quat_bytes[i]) send_byte(quat_bytes[i]);

        while (sent_bytes < BYTE_TARGET) begin
            if (!held && sent_bytes >= 400) begin
                // sink holds off while packets keep coming, so the input backs up
                held = 1'b1;
                hold_token <= hold_token + 1;
            end
            if (!drained && sent_bytes >= 900) begin
                drained = 1'b1;
                pause_until_drained();
            end
            send_random_packet();
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (predictor.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
sv/cpp_pkg.sv
sv/controller_packet_parser.sv
bench/tb.sv
